[rtl/core/olie_pkg.sv]
// olie_pkg: shared types and codes for the ordered list insert/erase unit
// request/response word structs, action and status codes, cell command struct
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package olie_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int MAX_DEPTH     = 256;
   // wide enough for any index, count or fill count up to MAX_DEPTH
   localparam int POS_W         = $clog2(MAX_DEPTH + 1);

   localparam int ACTION_W = 3;
   localparam int INDEX_W  = 5;
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH   = 3'd0,
      ACT_POP    = 3'd1,
      ACT_INSERT = 3'd2,
      ACT_ERASE  = 3'd3,
      ACT_READ   = 3'd4,
      ACT_FILL   = 3'd5
   } action_type;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

   typedef struct packed {
      logic [ACTION_W-1:0]       action;
      logic [INDEX_W-1:0]        index;
      logic signed [VALUE_W-1:0] value;
      logic [INDEX_W-1:0]        fill_count;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] read_value;
      logic [COUNT_W-1:0]        count_after;
      logic [STATUS_W-1:0]       status;
   } rsp_type;

   // broadcast to every cell of the chain
   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_WRITE,
      CMD_INSERT,
      CMD_ERASE,
      CMD_FILL
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type              kind;
      logic [POS_W-1:0]          pos;
      logic signed [VALUE_W-1:0] value;
   } cmd_type;

endpackage

`default_nettype wire

[rtl/core/ordered_list_insert_erase_unit.sv]
// ordered_list_insert_erase_unit: bounded ordered list built as a row of cells
// depends on olie_pkg and olie_cell
//
//   channel | direction | handshake             | word
//   req     | in        | req_valid / req_ready | req_word (olie_pkg::req_type)
//   rsp     | out       | rsp_valid / rsp_ready | rsp_word (olie_pkg::rsp_type)
//
// one word is taken per cycle unless rsp stalls; cells shift or load in the same cycle
// the response is registered and appears in the cycle after the request word is taken
// the output register frees itself when taken, so a new word is taken in that same cycle
// a stalled response holds req_ready low until rsp_ready comes back
// reset clears the live count and the response valid; entries are not cleared
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_insert_erase_unit #(
   parameter int DEPTH = olie_pkg::DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire olie_pkg::req_type req_word,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output olie_pkg::rsp_type      rsp_word
);
   import olie_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int AW    = $clog2(DEPTH);
   localparam logic [POS_W-1:0] DEPTH_POS = POS_W'(DEPTH);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             fire;
   logic             full;
   cmd_type          cmd;
   logic [POS_W-1:0] cnt_pos, idx_pos, fcnt_pos;
   logic signed [VALUE_W-1:0] cell_entry [DEPTH];
   logic signed [VALUE_W-1:0] rd_entry;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid && req_ready;

   assign cnt_pos  = POS_W'(count_ff);
   assign idx_pos  = POS_W'(req_word.index);
   assign fcnt_pos = POS_W'(req_word.fill_count);
   assign full     = (cnt_pos == DEPTH_POS);
   assign rd_entry = cell_entry[idx_pos[AW-1:0]];

   // decode the request into a cell command, new count and response
   always_comb begin
      cmd.kind          = CMD_HOLD;
      cmd.pos           = idx_pos;
      cmd.value         = req_word.value;
      count_in          = count_ff;
      rsp_in.read_value = '0;
      rsp_in.status     = ST_OK;
      unique case (req_word.action)
         ACT_PUSH: begin
            if (full) begin
               rsp_in.status = ST_FULL;
            end else begin
               cmd.kind = CMD_WRITE;
               cmd.pos  = cnt_pos;
               count_in = count_ff + 1'b1;
            end
         end
         ACT_POP: begin
            if (count_ff == '0) rsp_in.status = ST_EMPTY;
            else count_in = count_ff - 1'b1;
         end
         ACT_INSERT: begin
            // range check wins over the full check
            if (idx_pos > cnt_pos) begin
               rsp_in.status = ST_RANGE;
            end else if (full) begin
               rsp_in.status = ST_FULL;
            end else begin
               cmd.kind = CMD_INSERT;
               count_in = count_ff + 1'b1;
            end
         end
         ACT_ERASE: begin
            if (idx_pos >= cnt_pos) begin
               rsp_in.status = ST_RANGE;
            end else begin
               cmd.kind = CMD_ERASE;
               count_in = count_ff - 1'b1;
            end
         end
         ACT_READ: begin
            if (idx_pos >= cnt_pos) rsp_in.status = ST_RANGE;
            else rsp_in.read_value = rd_entry;
         end
         ACT_FILL: begin
            if (fcnt_pos > DEPTH_POS) begin
               rsp_in.status = ST_RANGE;
            end else begin
               cmd.kind = CMD_FILL;
               cmd.pos  = fcnt_pos;
               count_in = CNT_W'(fcnt_pos);
            end
         end
         default: begin
            rsp_in.status = ST_OK;
         end
      endcase
      if (!fire) begin
         cmd.kind = CMD_HOLD;
         count_in = count_ff;
      end
      rsp_in.count_after = COUNT_W'(count_in);
      rsp_valid_in       = fire || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (fire) rsp_ff <= rsp_in;
   end

   // row of cells, each wired to its neighbors
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [VALUE_W-1:0] left_entry, right_entry;
      if (i == 0) begin : g_first
         assign left_entry = cell_entry[i];
      end else begin : g_mid_l
         assign left_entry = cell_entry[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_entry = cell_entry[i];
      end else begin : g_mid_r
         assign right_entry = cell_entry[i+1];
      end
      olie_cell #(
         .INDEX(i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .left_entry (left_entry),
         .right_entry(right_entry),
         .entry      (cell_entry[i])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      POS_W'(count_ff) <= DEPTH_POS)
      else $error("live count above depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      fire && req_word.action == ACT_PUSH && !full |=> count_ff == $past(count_ff) + 1'b1)
      else $error("push did not grow the count");

   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      fire && req_word.action == ACT_POP && count_ff == '0 |=>
         rsp_ff.status == ST_EMPTY && count_ff == '0)
      else $error("pop on empty list not flagged");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff && rsp_ff.count_after == COUNT_W'(count_ff))
      else $error("response missing or count mismatch");

endmodule

`default_nettype wire

[rtl/core/olie_cell.sv]
// olie_cell: one list entry; loads the broadcast value or a neighbor's entry
// depends on olie_pkg
`timescale 1ns / 1ps
`default_nettype none

module olie_cell #(
   parameter int INDEX = 0
) (
   input  wire logic                               clock,
   input  wire olie_pkg::cmd_type                  cmd,
   input  wire logic signed [olie_pkg::VALUE_W-1:0] left_entry,
   input  wire logic signed [olie_pkg::VALUE_W-1:0] right_entry,
   output logic signed [olie_pkg::VALUE_W-1:0]      entry
);
   import olie_pkg::*;

   localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

   logic signed [VALUE_W-1:0] entry_ff, entry_in;

   always_comb begin
      entry_in = entry_ff;
      unique case (cmd.kind)
         CMD_HOLD: begin
            entry_in = entry_ff;
         end
         CMD_WRITE: begin
            if (MY_POS == cmd.pos) entry_in = cmd.value;
         end
         CMD_INSERT: begin
            // entries at and above the slot move up one place
            if (MY_POS == cmd.pos) entry_in = cmd.value;
            else if (MY_POS > cmd.pos) entry_in = left_entry;
         end
         CMD_ERASE: begin
            if (MY_POS >= cmd.pos) entry_in = right_entry;
         end
         CMD_FILL: begin
            if (MY_POS < cmd.pos) entry_in = cmd.value;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire
